// File: rtl/core/jdc_pkg.sv
// jdc_pkg: constants, register indexes and the arctangent table of the
// joystick direction classifier. No dependencies; imported by the classifier core.
package jdc_pkg;

   // parameter defaults
   localparam int ADC_BITS_DEF     = 12;
   localparam int CORDIC_STEPS_DEF = 16;

   // fixed-point formats
   localparam int PRESCALE_BITS = 20;
   localparam int TABLE_LEN     = 24;
   localparam int IDX_W         = 5;

   // configuration register indexes and reset values
   localparam logic CSR_DEAD_ZONE = 1'b0;
   localparam logic CSR_HOLDOFF   = 1'b1;
   localparam logic [11:0] DEAD_ZONE_RST = 12'd410;
   localparam logic [15:0] HOLDOFF_RST   = 16'd50;

   // angle scaling and sector quantization
   localparam logic [11:0] TENTHS_PER_TURN = 12'd3600;
   localparam int          SECTOR_SPAN     = 450;
   localparam int          SECTOR_HALF     = 225;
   localparam logic [3:0]  SECTOR_CENTRE   = 4'd8;
   localparam logic [31:0] HALF_TURN       = 32'h8000_0000;

   // atan(2^-i) in binary turns, 2^32 = 360 degrees
   function automatic logic [31:0] jdc_atan(input logic [IDX_W-1:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:    val = 32'd536870912;
         5'd1:    val = 32'd316933406;
         5'd2:    val = 32'd167458907;
         5'd3:    val = 32'd85004756;
         5'd4:    val = 32'd42667331;
         5'd5:    val = 32'd21354465;
         5'd6:    val = 32'd10679838;
         5'd7:    val = 32'd5340245;
         5'd8:    val = 32'd2670163;
         5'd9:    val = 32'd1335087;
         5'd10:   val = 32'd667544;
         5'd11:   val = 32'd333772;
         5'd12:   val = 32'd166886;
         5'd13:   val = 32'd83443;
         5'd14:   val = 32'd41722;
         5'd15:   val = 32'd20861;
         5'd16:   val = 32'd10430;
         5'd17:   val = 32'd5215;
         5'd18:   val = 32'd2608;
         5'd19:   val = 32'd1304;
         5'd20:   val = 32'd652;
         5'd21:   val = 32'd326;
         5'd22:   val = 32'd163;
         5'd23:   val = 32'd81;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/core/joystick_direction_classifier_unit.sv
// joystick_direction_classifier_unit: joystick reading to centred position,
// angle, eight-way sector and debounced press. Depends on jdc_pkg.
//
// Usage:
//   req_ channel: one reading per item (two ADC samples, active-low button
//   level, millisecond timestamp). req_stall is high while an item is being
//   worked on, so one item is in flight at a time.
//   rsp_ channel: one result per item, held in an output register until the
//   receiver takes it; a new item is accepted while a result still waits.
//   csr_ port: index 0 dead zone, index 1 press hold-off in ms; write only
//   while the block is idle.
//   Timing: an accepted item passes through the load, rotation, scale and
//   done states before its result shows on rsp_valid; the next item is
//   accepted once the block is back in idle. The rotations are done by the
//   single shift-and-add CORDIC unit, one rotation per cycle. Centred
//   readings skip the rotations and go from load straight to scale.
//   If rsp_stall holds the previous result, the finished item waits in its
//   last state until the output register frees up.
//   Reset (synchronous): control state idle, no result pending, registers at
//   their defaults (dead zone 410, hold-off 50), last press time zero.
module joystick_direction_classifier_unit
   import jdc_pkg::*;
#(
   parameter int ADC_BITS     = ADC_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // reading in
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ADC_BITS-1:0] req_x_raw,
   input  logic [ADC_BITS-1:0] req_y_raw,
   input  logic                req_button_level,
   input  logic [31:0]         req_now_ms,
   // result out
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [12:0]  rsp_x_pos,
   output logic signed [12:0]  rsp_y_pos,
   output logic                rsp_pressed,
   output logic [3:0]          rsp_sector,
   output logic [11:0]         rsp_angle_tenths,
   // configuration
   input  logic                csr_write_en,
   input  logic                csr_index,
   input  logic [15:0]         csr_wdata
);

   localparam int CW         = ADC_BITS + PRESCALE_BITS + 3;
   localparam int FULL_SCALE = (1 << ADC_BITS) - 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_ITER  = 3'd2;
   localparam logic [2:0] S_SCALE = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic [ADC_BITS-1:0]  x_raw_ff, x_raw_in;
   logic [ADC_BITS-1:0]  y_raw_ff, y_raw_in;
   logic                 button_ff, button_in;
   logic [31:0]          now_ff, now_in;
   logic [31:0]          last_press_ff, last_press_in;
   logic [11:0]          dead_zone_ff, dead_zone_in;
   logic [15:0]          holdoff_ff, holdoff_in;
   logic signed [CW-1:0] x_ff, x_in;
   logic signed [CW-1:0] y_ff, y_in;
   logic [31:0]          z_ff, z_in;
   logic                 centre_ff, centre_in;
   logic                 pressed_ff, pressed_in;
   logic signed [12:0]   xpos_ff, xpos_in;
   logic signed [12:0]   ypos_ff, ypos_in;
   logic [11:0]          tenths_ff, tenths_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [12:0]   rsp_x_ff, rsp_x_in;
   logic signed [12:0]   rsp_y_ff, rsp_y_in;
   logic                 rsp_pressed_ff, rsp_pressed_in;
   logic [3:0]           rsp_sector_ff, rsp_sector_in;
   logic [11:0]          rsp_tenths_ff, rsp_tenths_in;

   logic signed [CW-1:0] x_cent, y_cent, x_abs, y_abs;
   logic signed [CW-1:0] x_pre, y_pre;
   logic signed [CW-1:0] xs, ys;
   logic [31:0]          press_gap;
   logic                 take_press;
   logic [43:0]          turn_prod;
   logic                 accept;
   logic                 out_free;

   // nearest sector, counted by thresholds
   function automatic logic [3:0] sector_of(input logic [11:0] t);
      logic [12:0] s;
      logic [3:0]  k;
      k = 4'd0;
      s = 13'(t) + 13'(SECTOR_HALF);
      for (int i = 1; i <= 8; i++) begin
         if (s >= 13'(i * SECTOR_SPAN)) begin
            k = k + 4'd1;
         end
      end
      return {1'b0, k[2:0]};
   endfunction

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign x_cent = CW'({x_raw_ff, 1'b0}) - CW'(FULL_SCALE);
   assign y_cent = CW'(FULL_SCALE) - CW'({y_raw_ff, 1'b0});
   assign x_abs  = x_cent[CW-1] ? -x_cent : x_cent;
   assign y_abs  = y_cent[CW-1] ? -y_cent : y_cent;
   assign x_pre  = x_cent <<< PRESCALE_BITS;
   assign y_pre  = y_cent <<< PRESCALE_BITS;

   assign press_gap  = now_ff - last_press_ff;
   assign take_press = !button_ff && (press_gap > {16'd0, holdoff_ff});

   // shared shift unit of the cordic
   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;

   assign turn_prod = 44'(z_ff) * 44'(TENTHS_PER_TURN);

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      x_raw_in       = x_raw_ff;
      y_raw_in       = y_raw_ff;
      button_in      = button_ff;
      now_in         = now_ff;
      last_press_in  = last_press_ff;
      dead_zone_in   = dead_zone_ff;
      holdoff_in     = holdoff_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      centre_in      = centre_ff;
      pressed_in     = pressed_ff;
      xpos_in        = xpos_ff;
      ypos_in        = ypos_ff;
      tenths_in      = tenths_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_pressed_in = rsp_pressed_ff;
      rsp_sector_in  = rsp_sector_ff;
      rsp_tenths_in  = rsp_tenths_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_DEAD_ZONE: dead_zone_in = csr_wdata[11:0];
            CSR_HOLDOFF:   holdoff_in   = csr_wdata;
            default:       ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               x_raw_in  = req_x_raw;
               y_raw_in  = req_y_raw;
               button_in = req_button_level;
               now_in    = req_now_ms;
               state_in  = S_LOAD;
            end
         end
         S_LOAD: begin
            xpos_in    = x_cent[12:0];
            ypos_in    = y_cent[12:0];
            pressed_in = take_press;
            if (take_press) begin
               last_press_in = now_ff;
            end
            centre_in = (x_abs < CW'(dead_zone_ff)) && (y_abs < CW'(dead_zone_ff));
            cnt_in    = '0;
            if (x_cent[CW-1]) begin
               x_in = -x_pre;
               y_in = -y_pre;
               z_in = HALF_TURN;
            end else begin
               x_in = x_pre;
               y_in = y_pre;
               z_in = '0;
            end
            // centre and the all-zero point skip the rotations with angle 0
            if (centre_in || (x_cent == '0 && y_cent == '0)) begin
               z_in     = '0;
               state_in = S_SCALE;
            end else begin
               state_in = S_ITER;
            end
         end
         S_ITER: begin
            if (y_ff > 0) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + jdc_atan(cnt_ff);
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - jdc_atan(cnt_ff);
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(CORDIC_STEPS - 1)) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            tenths_in = turn_prod[43:32];
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_x_in       = xpos_ff;
               rsp_y_in       = ypos_ff;
               rsp_pressed_in = pressed_ff;
               rsp_sector_in  = centre_ff ? SECTOR_CENTRE : sector_of(tenths_ff);
               rsp_tenths_in  = tenths_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         last_press_ff <= '0;
         dead_zone_ff  <= DEAD_ZONE_RST;
         holdoff_ff    <= HOLDOFF_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         last_press_ff <= last_press_in;
         dead_zone_ff  <= dead_zone_in;
         holdoff_ff    <= holdoff_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_raw_ff       <= x_raw_in;
      y_raw_ff       <= y_raw_in;
      button_ff      <= button_in;
      now_ff         <= now_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      z_ff           <= z_in;
      centre_ff      <= centre_in;
      pressed_ff     <= pressed_in;
      xpos_ff        <= xpos_in;
      ypos_ff        <= ypos_in;
      tenths_ff      <= tenths_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_pressed_ff <= rsp_pressed_in;
      rsp_sector_ff  <= rsp_sector_in;
      rsp_tenths_ff  <= rsp_tenths_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_x_pos        = rsp_x_ff;
   assign rsp_y_pos        = rsp_y_ff;
   assign rsp_pressed      = rsp_pressed_ff;
   assign rsp_sector       = rsp_sector_ff;
   assign rsp_angle_tenths = rsp_tenths_ff;

   // an accepted item always starts with the load step
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_LOAD)
      else $error("accepted item did not enter load");

   // rotation counter never passes the configured step count
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ITER |-> cnt_ff < IDX_W'(CORDIC_STEPS))
      else $error("cordic step counter out of range");

   // centred results carry angle zero
   a_centre_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sector == SECTOR_CENTRE |-> rsp_angle_tenths == 12'd0)
      else $error("centre result with nonzero angle");

   // a waiting result is not overwritten while stalled
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_angle_tenths)
         && $stable(rsp_sector))
      else $error("stalled result changed");

endmodule

// File: tb/joystick_direction_classifier_unit_tb.sv
`timescale 1ns / 1ps
// joystick_direction_classifier_unit_tb: self-checking bench for the joystick classifier,
// with its own CORDIC angle and press-timing predictor. Needs jdc_pkg and the classifier.
module joystick_direction_classifier_unit_tb;
   import jdc_pkg::*;

   localparam int FULL_SCALE      = (1 << ADC_BITS_DEF) - 1;
   localparam int CORDIC_ITERS    = CORDIC_STEPS_DEF;
   localparam int LONG_HOLD       = 400;
   localparam int DRAIN_LIMIT     = 2000;
   localparam int MAX_REPORTS     = 40;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 280;
   localparam int DIRECTED_ROWS   = 24;

   // atan(2^-i) in binary turns
   localparam logic [31:0] ATAN_TURNS [24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct packed {
      logic [11:0] x_raw;
      logic [11:0] y_raw;
      logic        button_level;
      logic [31:0] now_ms;
   } reading_t;

   typedef struct packed {
      logic signed [12:0] x_pos;
      logic signed [12:0] y_pos;
      logic               pressed;
      logic [3:0]         sector;
      logic [11:0]        angle_tenths;
   } direction_t;

   typedef struct packed {
      reading_t   rd;
      logic       typed;
      direction_t want;
   } directed_row_t;

   localparam direction_t NO_WANT = '0;

   // typed rows are centred readings, where angle and sector are fixed;
   // starts from reset values: dead zone 410, hold-off 50, last press 0
   localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
      '{'{12'd2048, 12'd2047, 1'b1, 32'd0},
        1'b1, '{13'sd1, 13'sd1, 1'b0, SECTOR_CENTRE, 12'd0}},
      // hold-off not yet exceeded, then just exceeded
      '{'{12'd2048, 12'd2048, 1'b0, 32'd50},
        1'b1, '{13'sd1, -13'sd1, 1'b0, SECTOR_CENTRE, 12'd0}},
      '{'{12'd2048, 12'd2048, 1'b0, 32'd51},
        1'b1, '{13'sd1, -13'sd1, 1'b1, SECTOR_CENTRE, 12'd0}},
      '{'{12'd2048, 12'd2048, 1'b0, 32'd101},
        1'b1, '{13'sd1, -13'sd1, 1'b0, SECTOR_CENTRE, 12'd0}},
      '{'{12'd2048, 12'd2048, 1'b0, 32'd102},
        1'b1, '{13'sd1, -13'sd1, 1'b1, SECTOR_CENTRE, 12'd0}},
      '{'{12'd2048, 12'd2048, 1'b1, 32'd5000},
        1'b1, '{13'sd1, -13'sd1, 1'b0, SECTOR_CENTRE, 12'd0}},
      // timestamp wrapping through zero
      '{'{12'd2048, 12'd2048, 1'b0, 32'hFFFF_FFFF},
        1'b1, '{13'sd1, -13'sd1, 1'b1, SECTOR_CENTRE, 12'd0}},
      '{'{12'd2048, 12'd2048, 1'b0, 32'd49},
        1'b1, '{13'sd1, -13'sd1, 1'b0, SECTOR_CENTRE, 12'd0}},
      '{'{12'd2048, 12'd2048, 1'b0, 32'd50},
        1'b1, '{13'sd1, -13'sd1, 1'b1, SECTOR_CENTRE, 12'd0}},
      // just inside the dead zone on each axis
      '{'{12'd2252, 12'd2047, 1'b1, 32'd0},
        1'b1, '{13'sd409, 13'sd1, 1'b0, SECTOR_CENTRE, 12'd0}},
      '{'{12'd2047, 12'd1843, 1'b1, 32'd0},
        1'b1, '{-13'sd1, 13'sd409, 1'b0, SECTOR_CENTRE, 12'd0}},
      '{'{12'd1843, 12'd2252, 1'b1, 32'd0},
        1'b1, '{-13'sd409, -13'sd409, 1'b0, SECTOR_CENTRE, 12'd0}},
      // just outside, corners, axes either side, left half-plane, diagonal
      '{'{12'd2253, 12'd2047, 1'b1, 32'd0},          1'b0, NO_WANT},
      '{'{12'd0,    12'd0,    1'b0, 32'hAAAA_AAAA},  1'b0, NO_WANT},
      '{'{12'd4095, 12'd4095, 1'b1, 32'h5555_5555},  1'b0, NO_WANT},
      '{'{12'd0,    12'd4095, 1'b0, 32'hAAAA_AAAA},  1'b0, NO_WANT},
      '{'{12'd4095, 12'd0,    1'b1, 32'd0},          1'b0, NO_WANT},
      '{'{12'd4095, 12'd2047, 1'b1, 32'd0},          1'b0, NO_WANT},
      '{'{12'd4095, 12'd2048, 1'b1, 32'd0},          1'b0, NO_WANT},
      '{'{12'd0,    12'd2047, 1'b1, 32'd0},          1'b0, NO_WANT},
      '{'{12'd0,    12'd2048, 1'b1, 32'd0},          1'b0, NO_WANT},
      '{'{12'd2047, 12'd0,    1'b1, 32'd0},          1'b0, NO_WANT},
      '{'{12'd2048, 12'd4095, 1'b1, 32'd0},          1'b0, NO_WANT},
      '{'{12'd3000, 12'd1095, 1'b1, 32'd0},          1'b0, NO_WANT}
   };

   localparam logic [11:0] EDGE_RAW [6] = '{12'd0, 12'd1, 12'd2047, 12'd2048, 12'd4094, 12'd4095};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [11:0]         req_x_raw = '0;
   logic [11:0]         req_y_raw = '0;
   logic                req_button_level = 1'b1;
   logic [31:0]         req_now_ms = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [12:0]  rsp_x_pos;
   logic signed [12:0]  rsp_y_pos;
   logic                rsp_pressed;
   logic [3:0]          rsp_sector;
   logic [11:0]         rsp_angle_tenths;
   logic                csr_write_en = 1'b0;
   logic                csr_index = CSR_DEAD_ZONE;
   logic [15:0]         csr_wdata = '0;

   // predictor copy of the registers and the press state
   logic [11:0] dead_zone_cfg = DEAD_ZONE_RST;
   logic [15:0] holdoff_cfg   = HOLDOFF_RST;
   logic [31:0] last_press_ms = '0;
   logic [31:0] stamp_ms      = '0;

   direction_t  expected_q [$];
   int          mismatch_count  = 0;
   int          items_sent      = 0;
   int          results_checked = 0;
   int          presses_seen    = 0;
   int          centred_seen    = 0;
   logic [8:0]  sectors_seen    = '0;
   int          send_idle_pct   = 28;
   int          recv_idle_pct   = 50;
   int          holds_requested = 0;
   int          holds_done      = 0;

   joystick_direction_classifier_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_x_raw        (req_x_raw),
      .req_y_raw        (req_y_raw),
      .req_button_level (req_button_level),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_x_pos        (rsp_x_pos),
      .rsp_y_pos        (rsp_y_pos),
      .rsp_pressed      (rsp_pressed),
      .rsp_sector       (rsp_sector),
      .rsp_angle_tenths (rsp_angle_tenths),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS) begin
         $display("mismatch: %s", msg);
      end
      mismatch_count++;
   endtask

   // vectoring CORDIC, angle in binary turns
   function automatic logic [31:0] cordic_turns(input longint ax, input longint ay);
      longint      vx, vy, sx, sy;
      logic [31:0] z;
      int          i;
      z = '0;
      if (ax == 0 && ay == 0) begin
         return '0;
      end
      vx = ax <<< PRESCALE_BITS;
      vy = ay <<< PRESCALE_BITS;
      if (vx < 0) begin
         vx = -vx;
         vy = -vy;
         z  = HALF_TURN;
      end
      for (i = 0; i < CORDIC_ITERS && i < TABLE_LEN; i++) begin
         sx = vx >>> i;
         sy = vy >>> i;
         if (vy > 0) begin
            vx = vx + sy;
            vy = vy - sx;
            z  = z + ATAN_TURNS[i];
         end else begin
            vx = vx - sy;
            vy = vy + sx;
            z  = z - ATAN_TURNS[i];
         end
      end
      return z;
   endfunction

   // expected result of one reading; updates the last press time
   function automatic direction_t classify_reading(input reading_t rd);
      direction_t  res;
      int          cx, cy, tenths, sect;
      logic [31:0] turns;
      logic [63:0] scaled;
      cx = 2 * int'(rd.x_raw) - FULL_SCALE;
      cy = FULL_SCALE - 2 * int'(rd.y_raw);
      res.pressed = 1'b0;
      if (!rd.button_level && (rd.now_ms - last_press_ms) > {16'b0, holdoff_cfg}) begin
         last_press_ms = rd.now_ms;
         res.pressed   = 1'b1;
      end
      if (((cx < 0) ? -cx : cx) < int'(dead_zone_cfg) &&
          ((cy < 0) ? -cy : cy) < int'(dead_zone_cfg)) begin
         tenths = 0;
         sect   = int'(SECTOR_CENTRE);
      end else begin
         turns  = cordic_turns(longint'(cx), longint'(cy));
         scaled = 64'(turns) * 64'(TENTHS_PER_TURN);
         tenths = int'(scaled[63:32]);
         sect   = ((tenths + SECTOR_HALF) / SECTOR_SPAN) % 8;
      end
      res.x_pos        = cx[12:0];
      res.y_pos        = cy[12:0];
      res.sector       = sect[3:0];
      res.angle_tenths = tenths[11:0];
      return res;
   endfunction

   function automatic logic [11:0] to_raw(input int v);
      if (v < 0) begin
         return '0;
      end
      if (v > FULL_SCALE) begin
         return 12'(FULL_SCALE);
      end
      return 12'(v);
   endfunction

   function automatic reading_t random_reading();
      reading_t rd;
      int       cx, cy, d, dz, t;
      dz = int'(dead_zone_cfg);
      case ($urandom_range(0, 7))
         3: begin
            // hugging the dead zone edge
            cx = dz + int'($urandom_range(0, 6)) - 3;
            if ($urandom_range(0, 1)) begin
               cy = dz + int'($urandom_range(0, 6)) - 3;
            end else begin
               cy = int'($urandom_range(0, 2 * dz)) - dz;
            end
            if ($urandom_range(0, 1)) cx = -cx;
            if ($urandom_range(0, 1)) cy = -cy;
            if ($urandom_range(0, 1)) begin
               t  = cx;
               cx = cy;
               cy = t;
            end
            rd.x_raw = to_raw((cx + FULL_SCALE) / 2);
            rd.y_raw = to_raw((FULL_SCALE - cy) / 2);
         end
         4: begin
            // along a diagonal
            rd.x_raw = 12'($urandom);
            d = int'($urandom_range(0, 8)) - 4;
            if ($urandom_range(0, 1)) begin
               rd.y_raw = to_raw(int'(rd.x_raw) + d);
            end else begin
               rd.y_raw = to_raw(FULL_SCALE - int'(rd.x_raw) + d);
            end
         end
         5: begin
            // along an axis
            d = int'($urandom_range(0, 8)) - 4;
            if ($urandom_range(0, 1)) begin
               rd.x_raw = 12'($urandom);
               rd.y_raw = to_raw(2048 + d);
            end else begin
               rd.y_raw = 12'($urandom);
               rd.x_raw = to_raw(2048 + d);
            end
         end
         6: begin
            rd.x_raw = EDGE_RAW[$urandom_range(0, 5)];
            rd.y_raw = EDGE_RAW[$urandom_range(0, 5)];
         end
         7: begin
            cx = int'($urandom_range(0, 2 * dz)) - dz;
            cy = int'($urandom_range(0, 2 * dz)) - dz;
            rd.x_raw = to_raw((cx + FULL_SCALE) / 2);
            rd.y_raw = to_raw((FULL_SCALE - cy) / 2);
         end
         default: begin
            rd.x_raw = 12'($urandom);
            rd.y_raw = 12'($urandom);
         end
      endcase
      rd.button_level = ($urandom_range(0, 99) < 35);
      // timestamps mostly step around the hold-off so presses land on both sides
      case ($urandom_range(0, 15))
         0:       stamp_ms = $urandom;
         1:       stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
         2:       stamp_ms = stamp_ms + $urandom_range(0, 200000);
         default: stamp_ms = stamp_ms + $urandom_range(0, 2 * int'(holdoff_cfg) + 4);
      endcase
      rd.now_ms = stamp_ms;
      return rd;
   endfunction

   task automatic offer_reading(input reading_t rd, input logic typed, input direction_t want);
      direction_t predicted;
      int         gap;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 30);
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_x_raw        <= rd.x_raw;
      req_y_raw        <= rd.y_raw;
      req_button_level <= rd.button_level;
      req_now_ms       <= rd.now_ms;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      predicted = classify_reading(rd);
      expected_q.push_back(typed ? want : predicted);
   endtask

   task automatic set_config(input logic [15:0] dz, input logic [15:0] ho);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_DEAD_ZONE;
      csr_wdata    <= dz;
      @(posedge clock);
      csr_index    <= CSR_HOLDOFF;
      csr_wdata    <= ho;
      @(posedge clock);
      csr_write_en <= 1'b0;
      dead_zone_cfg = dz[11:0];
      holdoff_cfg   = ho;
   endtask

   task automatic drain_results();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      while (expected_q.size() != 0) begin
         report_mismatch("result never arrived for an accepted item");
         void'(expected_q.pop_front());
      end
      repeat (CORDIC_ITERS + 4) @(posedge clock);
   endtask

   task automatic check_direction(input direction_t got);
      direction_t want;
      if (expected_q.size() == 0) begin
         report_mismatch($sformatf("result with no item outstanding: x_pos %0d y_pos %0d",
                                   got.x_pos, got.y_pos));
      end else begin
         want = expected_q.pop_front();
         if (got.x_pos !== want.x_pos)
            report_mismatch($sformatf("result %0d x_pos %0d, expected %0d",
                                      results_checked, got.x_pos, want.x_pos));
         if (got.y_pos !== want.y_pos)
            report_mismatch($sformatf("result %0d y_pos %0d, expected %0d",
                                      results_checked, got.y_pos, want.y_pos));
         if (got.pressed !== want.pressed)
            report_mismatch($sformatf("result %0d pressed %b, expected %b",
                                      results_checked, got.pressed, want.pressed));
         if (got.sector !== want.sector)
            report_mismatch($sformatf("result %0d sector %0d, expected %0d",
                                      results_checked, got.sector, want.sector));
         if (got.angle_tenths !== want.angle_tenths)
            report_mismatch($sformatf("result %0d angle_tenths %0d, expected %0d",
                                      results_checked, got.angle_tenths, want.angle_tenths));
         results_checked++;
         if (want.pressed) presses_seen++;
         if (want.sector == SECTOR_CENTRE) centred_seen++;
         if (want.sector <= SECTOR_CENTRE) sectors_seen[want.sector] = 1'b1;
      end
   endtask

   // receiver: random stalls plus long hold-offs on request
   initial begin
      int         hold_left;
      direction_t got;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = {rsp_x_pos, rsp_y_pos, rsp_pressed, rsp_sector, rsp_angle_tenths};
            check_direction(got);
         end
         if (hold_left > 0) begin
            hold_left--;
         end else if (holds_done != holds_requested) begin
            holds_done++;
            hold_left = LONG_HOLD;
         end
         rsp_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   initial begin
      int          ph, k, r;
      logic [15:0] dz, ho;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < DIRECTED_ROWS; r++) begin
         offer_reading(DIRECTED[r].rd, DIRECTED[r].typed, DIRECTED[r].want);
      end
      drain_results();

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       begin dz = 16'hF19A; ho = 16'd50;   end  // upper bits must be dropped
            1:       begin dz = 16'd0;    ho = 16'd0;    end
            2:       begin dz = 16'd4095; ho = 16'hFFFF; end
            3:       begin dz = 16'($urandom); ho = 16'($urandom); end
            4:       begin dz = 16'd1;    ho = 16'd1;    end
            default: begin
               dz = 16'($urandom_range(0, 1200));
               ho = 16'($urandom_range(0, 300));
            end
         endcase
         send_idle_pct  = (ph < 2) ? 28 : (ph < 4) ? 50 : 0;
         recv_idle_pct <= (ph < 2) ? 50 : (ph < 4) ? 28 : 0;
         set_config(dz, ho);
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            // back up the output so the block fills and stalls its input
            if (k == 40 && (ph == 0 || ph == 4)) holds_requested <= holds_requested + 1;
            offer_reading(random_reading(), 1'b0, NO_WANT);
         end
         drain_results();
      end

      $display("summary: %0d items sent, %0d results checked, %0d presses, %0d centred",
               items_sent, results_checked, presses_seen, centred_seen);
      $display("summary: sectors reached %b, dead zone 0..4095, hold-off 0..65535, two long stalls",
               sectors_seen);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
